// ===== rtl/cmi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmi_pkg
// Shared constants and types of the complex 2x2 matrix inverse unit.
// ----------------------------------------------------------------------------
package cmi_pkg;

    // default field formats
    localparam int IN_WIDTH_DEF  = 16;
    localparam int FRAC_BITS_DEF = 14;
    localparam int OUT_WIDTH_DEF = 24;

    // entries of the queue between the determinant front and the divide back
    localparam int QUEUE_DEPTH = 4;

    // status of the middle queue as seen by its producer and its consumer
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== rtl/cmi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmi_front
// Accepts items, forms the complex determinant p + iq and flags singular ones.
// ----------------------------------------------------------------------------
module cmi_front #(
    parameter int IN_WIDTH = cmi_pkg::IN_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [IN_WIDTH-1:0]        a_re,
    input  logic signed [IN_WIDTH-1:0]        a_im,
    input  logic signed [IN_WIDTH-1:0]        b_re,
    input  logic signed [IN_WIDTH-1:0]        b_im,
    input  logic signed [IN_WIDTH-1:0]        c_re,
    input  logic signed [IN_WIDTH-1:0]        c_im,
    input  logic signed [IN_WIDTH-1:0]        d_re,
    input  logic signed [IN_WIDTH-1:0]        d_im,
    input  cmi_pkg::qstat_t                   qstat,
    output logic                              q_push,
    output logic [8*IN_WIDTH+2*(2*IN_WIDTH+2):0] q_data
);

    localparam int W  = IN_WIDTH;
    localparam int PW = 2 * W + 2;

    logic                   adv;
    logic                   f1_vld_reg;
    logic                   f2_vld_reg;
    logic [8*W-1:0]         e1_reg;
    logic [8*W-1:0]         e2_reg;
    logic signed [2*W-1:0]  pr_reg [8];
    logic signed [PW-1:0]   p_reg;
    logic signed [PW-1:0]   q_reg;
    logic                   sing_reg;
    logic signed [PW-1:0]   p_next;
    logic signed [PW-1:0]   q_next;

    // only a full queue with a finished item in stage two holds the front
    assign adv    = !(f2_vld_reg && qstat.full);
    assign full   = !adv;
    assign q_push = f2_vld_reg && !qstat.full;
    assign q_data = {e2_reg, p_reg, q_reg, sing_reg};

    always_comb
    begin
        p_next = PW'(pr_reg[0]) - PW'(pr_reg[1]) - PW'(pr_reg[2]) + PW'(pr_reg[3]);
        q_next = PW'(pr_reg[4]) + PW'(pr_reg[5]) - PW'(pr_reg[6]) - PW'(pr_reg[7]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_vld_reg <= push;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg    <= {a_re, a_im, b_re, b_im, c_re, c_im, d_re, d_im};
            pr_reg[0] <= a_re * d_re;
            pr_reg[1] <= a_im * d_im;
            pr_reg[2] <= b_re * c_re;
            pr_reg[3] <= b_im * c_im;
            pr_reg[4] <= a_re * d_im;
            pr_reg[5] <= a_im * d_re;
            pr_reg[6] <= b_re * c_im;
            pr_reg[7] <= b_im * c_re;
            e2_reg    <= e1_reg;
            p_reg     <= p_next;
            q_reg     <= q_next;
            sing_reg  <= (p_next == '0) && (q_next == '0);
        end
    end

endmodule

// ===== rtl/cmi_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmi_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module cmi_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cmi_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output cmi_pkg::qstat_t  qstat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [CW-1:0]    cnt_reg;

    assign qstat.full  = (cnt_reg == CW'(DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign rd_data     = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_data;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== rtl/cmi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmi_back
// Numerators, |det|^2, per-bit restoring divide, rounding and saturation.
// ----------------------------------------------------------------------------
module cmi_back #(
    parameter int IN_WIDTH  = cmi_pkg::IN_WIDTH_DEF,
    parameter int FRAC_BITS = cmi_pkg::FRAC_BITS_DEF,
    parameter int OUT_WIDTH = cmi_pkg::OUT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cmi_pkg::qstat_t                   qstat,
    input  logic [8*IN_WIDTH+2*(2*IN_WIDTH+2):0] q_data,
    output logic                              q_pop,
    input  logic                              pop,
    output logic                              empty,
    output logic [7:0][OUT_WIDTH-1:0]         res,
    output logic                              singular,
    output logic                              saturated
);

    localparam int W  = IN_WIDTH;
    localparam int PW = 2 * W + 2;              // determinant parts
    localparam int DW = 4 * W + 2;              // |det|^2
    localparam int NW = 3 * W + 2;              // signed numerators
    localparam int MW = NW - 1 + 2 * FRAC_BITS + 1; // 2*|num|*2^(2F)
    localparam int K  = OUT_WIDTH + 1;          // quotient bits of 2N/D
    localparam int XW = (MW > DW + K) ? MW : DW + K;
    localparam int QW = 8 * W + 2 * PW + 1;
    localparam int NV = 4 + K;
    localparam int O  = OUT_WIDTH;

    logic adv;
    logic [NV-1:0] vld_reg;
    logic out_vld_reg;

    logic signed [W-1:0]  el_w [8];
    logic signed [PW-1:0] p_w;
    logic signed [PW-1:0] q_w;

    // stage B1: products
    logic signed [NW-1:0]   xp_reg [4];
    logic signed [NW-1:0]   yq_reg [4];
    logic signed [NW-1:0]   yp_reg [4];
    logic signed [NW-1:0]   xq_reg [4];
    logic signed [2*PW-1:0] pp_reg;
    logic signed [2*PW-1:0] qq_reg;
    logic                   sing1_reg;
    // stage B2: sums
    logic signed [NW-1:0]   num_reg [8];
    logic signed [2*PW-1:0] dsum_w;
    logic [DW-1:0]          den2_reg;
    logic                   sing2_reg;
    // stage B3: sign and magnitude
    logic [NW-1:0]          abs_w [8];
    logic [MW-1:0]          m3_reg [8];
    logic                   neg3_reg [8];
    logic [DW-1:0]          den3_reg;
    logic                   sing3_reg;
    // divide stages, index 0 is the range check
    logic [MW-1:0]          rem_reg [0:K-1][8];
    logic [DW-1:0]          den_reg [0:K-1];
    logic                   neg_reg [0:K][8];
    logic                   big_reg [0:K][8];
    logic                   sing_reg [0:K];
    logic [K-1:0]           q_reg [1:K][8];
    logic [XW-1:0]          dtop_w;
    // final rounding
    logic [K:0]             inc_w [8];
    logic [K-1:0]           rnd_w [8];
    logic [K-1:0]           lim_w [8];
    logic                   sat_w [8];
    logic [K-1:0]           mag_w [8];
    logic [O-1:0]           val_w [8];
    logic                   anysat_w;

    logic [O-1:0]           res_reg [8];
    logic                   sing_out_reg;
    logic                   sat_out_reg;

    assign adv   = !out_vld_reg || pop;
    assign q_pop = adv && !qstat.empty;
    assign empty = !out_vld_reg;
    assign singular  = sing_out_reg;
    assign saturated = sat_out_reg;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            el_w[k] = $signed(q_data[QW-1-k*W -: W]);
            res[k]  = res_reg[k];
        end
        p_w = $signed(q_data[2*PW:PW+1]);
        q_w = $signed(q_data[PW:1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NV-2:0], q_pop};
            out_vld_reg <= vld_reg[NV-1];
        end
    end

    // lanes: inv11 uses d, inv12 -b, inv21 -c, inv22 a
    for (genvar i = 0; i < 4; i++) begin : g_lane
        localparam int XI = (i == 0) ? 6 : (i == 1) ? 2 : (i == 2) ? 4 : 0;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                xp_reg[i] <= el_w[XI] * p_w;
                yq_reg[i] <= el_w[XI+1] * q_w;
                yp_reg[i] <= el_w[XI+1] * p_w;
                xq_reg[i] <= el_w[XI] * q_w;
                num_reg[2*i]   <= xp_reg[i] + yq_reg[i];
                num_reg[2*i+1] <= yp_reg[i] - xq_reg[i];
            end
        end
    end

    assign dsum_w = pp_reg + qq_reg;
    assign dtop_w = XW'(den3_reg) << K;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
            abs_w[k] = num_reg[k][NW-1] ? NW'(-num_reg[k]) : NW'(num_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_reg    <= p_w * p_w;
            qq_reg    <= q_w * q_w;
            sing1_reg <= q_data[0];
            den2_reg  <= dsum_w[DW-1:0];
            sing2_reg <= sing1_reg;
            den3_reg  <= den2_reg;
            sing3_reg <= sing2_reg;
            for (int k = 0; k < 8; k++)
            begin
                m3_reg[k]   <= {abs_w[k][NW-2:0], {(2*FRAC_BITS+1){1'b0}}};
                // off-diagonal parts carry the minus sign
                neg3_reg[k] <= num_reg[k][NW-1] ^ ((k >= 2) && (k <= 5));
            end
            // quotient range check: 2N >= D * 2^K saturates for sure
            den_reg[0]  <= den3_reg;
            sing_reg[0] <= sing3_reg;
            for (int k = 0; k < 8; k++)
            begin
                rem_reg[0][k] <= m3_reg[k];
                neg_reg[0][k] <= neg3_reg[k];
                big_reg[0][k] <= XW'(m3_reg[k]) >= dtop_w;
            end
        end
    end

    for (genvar s = 1; s <= K; s++) begin : g_div
        logic [XW-1:0] sub_w;
        logic          ge_w [8];
        logic [XW-1:0] dif_w [8];
        logic [K-1:0]  qprev_w [8];

        assign sub_w = XW'(den_reg[s-1]) << (K - s);

        always_comb
        begin
            for (int k = 0; k < 8; k++)
            begin
                ge_w[k]  = XW'(rem_reg[s-1][k]) >= sub_w;
                dif_w[k] = XW'(rem_reg[s-1][k]) - sub_w;
            end
        end

        if (s == 1) begin : g_first
            always_comb
            begin
                for (int k = 0; k < 8; k++)
                    qprev_w[k] = '0;
            end
        end else begin : g_next
            always_comb
            begin
                for (int k = 0; k < 8; k++)
                    qprev_w[k] = q_reg[s-1][k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sing_reg[s] <= sing_reg[s-1];
                for (int k = 0; k < 8; k++)
                begin
                    q_reg[s][k]   <= {qprev_w[k][K-2:0], ge_w[k]};
                    neg_reg[s][k] <= neg_reg[s-1][k];
                    big_reg[s][k] <= big_reg[s-1][k];
                end
            end
        end

        if (s < K) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    den_reg[s] <= den_reg[s-1];
                    for (int k = 0; k < 8; k++)
                        rem_reg[s][k] <= ge_w[k] ? dif_w[k][MW-1:0] : rem_reg[s-1][k];
                end
            end
        end
    end

    // round half away from zero: (floor(2N/D) + 1) / 2, then clip
    always_comb
    begin
        anysat_w = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            inc_w[k] = {1'b0, q_reg[K][k]} + 1'b1;
            rnd_w[k] = inc_w[k][K:1];
            lim_w[k] = neg_reg[K][k] ? {{(K-O){1'b0}}, 1'b1, {(O-1){1'b0}}}
                                     : {{(K-O+1){1'b0}}, {(O-1){1'b1}}};
            sat_w[k] = big_reg[K][k] || (rnd_w[k] > lim_w[k]);
            mag_w[k] = sat_w[k] ? lim_w[k] : rnd_w[k];
            val_w[k] = neg_reg[K][k] ? O'(~mag_w[k][O-1:0] + 1'b1) : mag_w[k][O-1:0];
            anysat_w = anysat_w | sat_w[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[NV-1])
        begin
            sing_out_reg <= sing_reg[K];
            sat_out_reg  <= !sing_reg[K] && anysat_w;
            for (int k = 0; k < 8; k++)
                res_reg[k] <= sing_reg[K] ? '0 : val_w[k];
        end
    end

endmodule

// ===== rtl/complex_2x2_matrix_inverse_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_2x2_matrix_inverse_unit
// Inverts one complex 2x2 matrix per item with exact rounded fixed point.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless a result waits unpopped; the back end
//   runs a restoring divide with one quotient bit per stage, OUT_WIDTH + 1
//   stages, all 8 parts in parallel.
// Reset: asynchronous, active low; empties the pipeline, the middle queue and
//   the result register. No configuration state.
// ----------------------------------------------------------------------------
// Structure:
//   front  - two stages: 8 real products, then det = p + iq and the
//            singular flag (p == 0 and q == 0).
//   queue  - a few entries, lets front and back stall independently.
//   back   - element * det products and |det|^2, numerator sums,
//            sign/magnitude with the 2^(2*FRAC_BITS) scale, a range check
//            that catches quotients too large for OUT_WIDTH + 1 bits,
//            the per-bit divide stages, then rounding (ties away from zero)
//            and clipping into the result register.
// The back pipeline moves as one unit whenever the result register is free
// or being popped; full is raised only when the queue is full and the
// front holds a finished item.
// ----------------------------------------------------------------------------
module complex_2x2_matrix_inverse_unit #(
    parameter int IN_WIDTH  = cmi_pkg::IN_WIDTH_DEF,
    parameter int FRAC_BITS = cmi_pkg::FRAC_BITS_DEF,
    parameter int OUT_WIDTH = cmi_pkg::OUT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic signed [IN_WIDTH-1:0]  a_re,
    input  logic signed [IN_WIDTH-1:0]  a_im,
    input  logic signed [IN_WIDTH-1:0]  b_re,
    input  logic signed [IN_WIDTH-1:0]  b_im,
    input  logic signed [IN_WIDTH-1:0]  c_re,
    input  logic signed [IN_WIDTH-1:0]  c_im,
    input  logic signed [IN_WIDTH-1:0]  d_re,
    input  logic signed [IN_WIDTH-1:0]  d_im,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [OUT_WIDTH-1:0] inv11_re,
    output logic signed [OUT_WIDTH-1:0] inv11_im,
    output logic signed [OUT_WIDTH-1:0] inv12_re,
    output logic signed [OUT_WIDTH-1:0] inv12_im,
    output logic signed [OUT_WIDTH-1:0] inv21_re,
    output logic signed [OUT_WIDTH-1:0] inv21_im,
    output logic signed [OUT_WIDTH-1:0] inv22_re,
    output logic signed [OUT_WIDTH-1:0] inv22_im,
    output logic                        singular,
    output logic                        saturated
);

    // item carried through the queue: 8 elements, p, q, singular flag
    localparam int QW = 8 * IN_WIDTH + 2 * (2 * IN_WIDTH + 2) + 1;

    cmi_pkg::qstat_t            qstat;
    logic                       q_push;
    logic                       q_pop;
    logic [QW-1:0]              q_wdata;
    logic [QW-1:0]              q_rdata;
    logic [7:0][OUT_WIDTH-1:0]  res;

    cmi_front #(
        .IN_WIDTH (IN_WIDTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .a_re   (a_re),
        .a_im   (a_im),
        .b_re   (b_re),
        .b_im   (b_im),
        .c_re   (c_re),
        .c_im   (c_im),
        .d_re   (d_re),
        .d_im   (d_im),
        .qstat  (qstat),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    cmi_queue #(
        .WIDTH (QW),
        .DEPTH (cmi_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wdata),
        .pop     (q_pop),
        .rd_data (q_rdata),
        .qstat   (qstat)
    );

    cmi_back #(
        .IN_WIDTH  (IN_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .OUT_WIDTH (OUT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .res       (res),
        .singular  (singular),
        .saturated (saturated)
    );

    // result order: d, -b, -c, a over det, real part first
    assign inv11_re = $signed(res[0]);
    assign inv11_im = $signed(res[1]);
    assign inv12_re = $signed(res[2]);
    assign inv12_im = $signed(res[3]);
    assign inv21_re = $signed(res[4]);
    assign inv21_im = $signed(res[5]);
    assign inv22_re = $signed(res[6]);
    assign inv22_im = $signed(res[7]);

    // a singular item shows all-zero parts and never a clip
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && singular) |-> (!saturated && res == '0))
        else $error("singular item with nonzero result");

endmodule

// ===== tb/complex_2x2_matrix_inverse_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_2x2_matrix_inverse_unit_test
// Self-checking bench for the complex 2x2 matrix inverse unit. A driver feeds
// matrices from a pending queue and a monitor checks every popped inverse
// against an exact wide-integer prediction, under several idle mixes.
// ----------------------------------------------------------------------------
module complex_2x2_matrix_inverse_unit_test;

    localparam int IW = cmi_pkg::IN_WIDTH_DEF;
    localparam int FB = cmi_pkg::FRAC_BITS_DEF;
    localparam int OW = cmi_pkg::OUT_WIDTH_DEF;
    localparam int HOLD_CYCLES = 300;   // long receiver stall, fills the unit
    localparam int DRAIN_CYCLES = 60;   // extra wait after the bench has drained

    // element order: a_re a_im b_re b_im c_re c_im d_re d_im
    typedef logic signed [7:0][IW-1:0] matrix_t;
    typedef struct packed {
        logic signed [7:0][OW-1:0] inv;  // inv11 re/im .. inv22 re/im
        logic singular;
        logic saturated;
    } inverse_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    matrix_t drv_m = '0;
    logic full, empty, singular, saturated;
    logic signed [OW-1:0] o11r, o11i, o12r, o12i, o21r, o21i, o22r, o22i;

    matrix_t pending_mats[$];
    inverse_t expected_inv[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    bit took = 1'b0;
    int mismatches = 0;
    int checked = 0;
    int singular_seen = 0;
    int sat_seen = 0;

    always #5 clk = ~clk;

    complex_2x2_matrix_inverse_unit uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .a_re(drv_m[7]), .a_im(drv_m[6]), .b_re(drv_m[5]), .b_im(drv_m[4]),
        .c_re(drv_m[3]), .c_im(drv_m[2]), .d_re(drv_m[1]), .d_im(drv_m[0]),
        .empty(empty), .pop(pop),
        .inv11_re(o11r), .inv11_im(o11i), .inv12_re(o12r), .inv12_im(o12i),
        .inv21_re(o21r), .inv21_im(o21i), .inv22_re(o22r), .inv22_im(o22i),
        .singular(singular), .saturated(saturated)
    );

    // Rounded (ties away from zero) and clipped num / den.
    function automatic logic signed [OW-1:0] round_div(logic signed [127:0] num,
                                                      logic signed [127:0] den,
                                                      ref bit sat);
        logic [127:0] mag, q, r, lim;
        mag = (num < 0) ? -num : num;
        q = mag / den;
        r = mag % den;
        if ((r << 1) >= den)
            q = q + 1;
        lim = (num < 0) ? (128'd1 << (OW - 1)) : ((128'd1 << (OW - 1)) - 1);
        if (q > lim)
        begin
            q = lim;
            sat = 1'b1;
        end
        return (num < 0) ? -q[OW-1:0] : q[OW-1:0];
    endfunction

    function automatic inverse_t invert_matrix(matrix_t m);
        logic signed [127:0] e[8];
        logic signed [127:0] p, q, den, ex, ey, nr, ni;
        inverse_t res;
        bit sat;
        sat = 1'b0;
        res = '0;
        for (int i = 0; i < 8; i++)
            e[i] = $signed(m[7 - i]);
        p = e[0] * e[6] - e[1] * e[7] - e[2] * e[4] + e[3] * e[5];
        q = e[0] * e[7] + e[1] * e[6] - e[2] * e[5] - e[3] * e[4];
        den = p * p + q * q;
        if (den == 0)
        begin
            res.singular = 1'b1;
            return res;
        end
        for (int k = 0; k < 4; k++)
        begin
            // numerators: d, -b, -c, a
            case (k)
                0: begin ex = e[6];  ey = e[7];  end
                1: begin ex = -e[2]; ey = -e[3]; end
                2: begin ex = -e[4]; ey = -e[5]; end
                default: begin ex = e[0]; ey = e[1]; end
            endcase
            nr = (ex * p + ey * q) <<< (2 * FB);
            ni = (ey * p - ex * q) <<< (2 * FB);
            res.inv[7 - 2 * k] = round_div(nr, den, sat);
            res.inv[6 - 2 * k] = round_div(ni, den, sat);
        end
        res.saturated = sat;
        return res;
    endfunction

    function automatic logic signed [IW-1:0] rand_elem(int mode);
        case (mode)
            0: return IW'($urandom_range(0, 127) - 64);      // tiny, often saturates
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return IW'($urandom);
        endcase
    endfunction

    function automatic matrix_t rand_matrix();
        matrix_t m;
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 8; i++)
            m[i] = rand_elem(mode == 6 ? 0 : (mode == 9 && i == 3) ? 1 : 2);
        if (mode == 7)
        begin
            // b = a, d = c: determinant exactly zero
            m[5] = m[7]; m[4] = m[6];
            m[1] = m[3]; m[0] = m[2];
        end
        else if (mode == 8)
        begin
            // strong real diagonal, small real off-diagonal, imaginary parts random
            m[7] = IW'(16384 + $signed($urandom_range(0, 4095)) - 2048);
            m[1] = IW'(16384 + $signed($urandom_range(0, 4095)) - 2048);
            m[5] = IW'($signed($urandom_range(0, 2047)) - 1024);
            m[3] = IW'($signed($urandom_range(0, 2047)) - 1024);
        end
        return m;
    endfunction

    // Driver: a new item is offered after the previous one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!push || took))
        begin
            if (pending_mats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                drv_m <= pending_mats.pop_front();
                push <= 1'b1;
            end
            else
                push <= 1'b0;
        end
    end

    // Receiver: random idling, plus one long hold-off counted here.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: check popped results, then log newly accepted items.
    always @(posedge clk)
    begin
        inverse_t got, want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                got.inv = {o11r, o11i, o12r, o12i, o21r, o21i, o22r, o22i};
                got.singular = singular;
                got.saturated = saturated;
                checked++;
                if (expected_inv.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result with no item pending: %h", got);
                end
                else
                begin
                    want = expected_inv.pop_front();
                    singular_seen += want.singular;
                    sat_seen += want.saturated;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            for (int i = 7; i >= 0; i--)
                                $display("ERROR: result %0d part %0d exp %0d got %0d",
                                         checked, 7 - i, want.inv[i], got.inv[i]);
                        if (mismatches <= 10)
                            $display("ERROR:   singular exp %b got %b, saturated exp %b got %b",
                                     want.singular, got.singular,
                                     want.saturated, got.saturated);
                    end
                end
            end
            took = push && !full;
            if (took)
                expected_inv.push_back(invert_matrix(drv_m));
        end
    end

    task automatic wait_drained();
        while (pending_mats.size() > 0 || push || expected_inv.size() > 0)
            @(posedge clk);
    endtask

    task automatic queue_random(int n);
        repeat (n)
            pending_mats.push_back(rand_matrix());
    endtask

    initial
    begin
        matrix_t m;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // phase 1: sender idles lightly, receiver heavily
        send_idle_pct = 22;
        recv_idle_pct = 86;
        pending_mats.push_back('0);                                 // zero matrix
        pending_mats.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                                16'sd0, 16'sd0, 16'sd16384, 16'sd0}); // identity
        pending_mats.push_back({8{16'sh7fff}});                     // singular
        pending_mats.push_back({8{16'sh8000}});                     // singular
        pending_mats.push_back({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                                16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
        pending_mats.push_back({16'sh7fff, 16'sh0, 16'sh0, 16'sh0,
                                16'sh0, 16'sh0, 16'sh7fff, 16'sh0});
        pending_mats.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd0,
                                16'sd0, 16'sd0, 16'sd1, 16'sd0});     // positive clip
        pending_mats.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd0,
                                16'sd0, 16'sd0, -16'sd1, 16'sd0});    // negative clip
        pending_mats.push_back({16'sd0, 16'sd1, 16'sd0, 16'sd0,
                                16'sd0, 16'sd0, 16'sd0, 16'sd1});     // a = d = i, det = -1
        // det = 32767 (a = 32767, d = 1), then det = 2 (a = 3, b = c = d = 1)
        pending_mats.push_back({16'sd32767, 16'sd0, 16'sd0, 16'sd0,
                                16'sd0, 16'sd0, 16'sd1, 16'sd0});
        pending_mats.push_back({16'sd3, 16'sd0, 16'sd1, 16'sd0,
                                16'sd1, 16'sd0, 16'sd1, 16'sd0});
        pending_mats.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                                16'sd16384, 16'sd0, 16'sd0, 16'sd0}); // anti-diagonal
        for (int i = 0; i < 8; i++)
        begin
            m = {8{16'sd16384}};
            m[i] = 16'sh8000;
            pending_mats.push_back(m);
        end
        queue_random(350);
        wait_drained();

        // phase 2: the other way round
        send_idle_pct = 86;
        recv_idle_pct = 22;
        queue_random(350);
        wait_drained();

        // phase 3: no idling, with one long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        queue_random(380);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d inverses (%0d singular, %0d saturated) over three idle mixes",
                 checked, singular_seen, sat_seen);
        $display("including a %0d-cycle receiver stall; %0d mismatches", HOLD_CYCLES,
                 mismatches);
        if (mismatches == 0 && expected_inv.size() == 0)
            $display("complex_2x2_matrix_inverse_unit_test OK");
        else
            $display("complex_2x2_matrix_inverse_unit_test NOT OK");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timeout with %0d results outstanding", expected_inv.size());
        $display("complex_2x2_matrix_inverse_unit_test NOT OK");
        $finish;
    end

endmodule
